// ----- hdl/ppg_pkg.sv -----
// Shared types, constants and helpers of the parametric path point generator.
package ppg_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int MAX_POINTS = 1024;
  localparam int CORDIC_STEPS = 24;

  localparam logic [1:0] STYLE_LINE   = 2'd0;
  localparam logic [1:0] STYLE_CIRCLE = 2'd1;
  localparam logic [1:0] STYLE_LEMNI  = 2'd2;

  localparam logic [1:0] REG_STYLE = 2'd0;
  localparam logic [1:0] REG_DIM   = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [32:0] CORDIC_K = 33'sh026DD3B6A;

  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  typedef struct packed {
    logic [1:0]         style;
    logic signed [31:0] dim;
    logic [CNT_W-1:0]   count;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] m;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- hdl/ppg_front.sv -----
// Front end: accepts a waypoint index, clamps count and index, registers the item.
module ppg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          full_i,
  input  logic [ppg_pkg::IDX_W-1:0]     point_index_i,
  input  ppg_pkg::cfg_t                 cfg_i,
  output logic                          push_o,
  output ppg_pkg::item_t                item_o
);
  import ppg_pkg::*;

  logic             fv_q, fv_d;
  item_t            item_q, item_d;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt = cfg_i.count;
    if (cnt < CNT_W'(2)) begin
      cnt = CNT_W'(2);
    end
    if (32'(cfg_i.count) > 32'(MAX_POINTS)) begin
      cnt = CNT_W'(MAX_POINTS);
    end
    item_d.m = cnt - CNT_W'(1);
    // saturate the index to the last waypoint
    if (CNT_W'(point_index_i) > item_d.m) begin
      item_d.idx = IDX_W'(item_d.m);
    end else begin
      item_d.idx = point_index_i;
    end
    fv_d = start_i & ~full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fv_d) begin
      item_q <= item_d;
    end
  end

  assign push_o = fv_q;
  assign item_o = item_q;

endmodule

// ----- hdl/ppg_fifo.sv -----
// Two-entry queue between the front end and the arithmetic back end.
module ppg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppg_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output ppg_pkg::item_t item_o
);
  import ppg_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop = pop_i & valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i & ~do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (~push_i & do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

// ----- hdl/ppg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; needs a < b * 2^QW.
module ppg_div #(
  parameter int AW = 42,
  parameter int BW = 11,
  parameter int QW = 33
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [QW-1:0] q_o
);

  logic [BW-1:0] r_src  [QW];
  logic [QW-1:0] lo_src [QW];
  logic [BW-1:0] b_src  [QW];
  logic [BW-1:0] r_q    [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [BW-1:0] b_q    [QW];
  logic [BW:0]   t_s    [QW];
  logic          ge_s   [QW];

  assign r_src[0]  = BW'(a_i[AW-1:QW]);
  assign lo_src[0] = a_i[QW-1:0];
  assign b_src[0]  = b_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign r_src[k]  = r_q[k-1];
      assign lo_src[k] = lo_q[k-1];
      assign b_src[k]  = b_q[k-1];
    end
    assign t_s[k]  = {r_src[k], lo_src[k][QW-1]};
    assign ge_s[k] = (t_s[k] >= {1'b0, b_src[k]});
    // shift the quotient bit in where the dividend bit leaves
    always_ff @(posedge clk_i) begin
      r_q[k]  <= ge_s[k] ? BW'(t_s[k] - {1'b0, b_src[k]}) : BW'(t_s[k]);
      lo_q[k] <= {lo_src[k][QW-2:0], ge_s[k]};
      b_q[k]  <= b_src[k];
    end
  end

  assign q_o = lo_q[QW-1];

endmodule

// ----- hdl/ppg_back.sv -----
// Back end: phase and line divisions, CORDIC, products and rounding divisions, one item a cycle.
module ppg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ppg_pkg::item_t       item_i,
  input  ppg_pkg::cfg_t        cfg_i,
  output logic                 done_o,
  output logic signed [31:0]   x_pos_o,
  output logic signed [31:0]   y_pos_o,
  output logic signed [31:0]   z_pos_o
);
  import ppg_pkg::*;

  localparam int PH_QW   = 33;
  localparam int LN_QW   = 41;
  localparam int LM_QW   = 33;
  localparam int T_MAP   = PH_QW + CORDIC_STEPS + 1;
  localparam int T_PROD  = T_MAP + 1;
  localparam int T_CIRC  = T_PROD + 1;
  localparam int T_MAG   = T_CIRC + 2;
  localparam int T_END   = T_MAG + LM_QW;
  localparam int DL_LNQ  = T_END - LN_QW;
  localparam int DL_CIRC = T_END - T_CIRC;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // entry stage
  logic [T_END:0]       vld_q;
  logic [IDX_W-1:0]     idx0_q;
  logic [CNT_W-1:0]     m0_q;
  logic [41:0]          lmag_q;
  logic                 lneg_q;
  logic signed [42:0]   lprod;
  logic signed [42:0]   labs;

  assign lprod = $signed({1'b0, item_i.idx}) * cfg_i.dim;
  assign labs  = lprod[42] ? -lprod : lprod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[T_END-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= item_i.idx;
    m0_q   <= item_i.m;
    lmag_q <= labs[41:0] + 42'(item_i.m >> 1);
    lneg_q <= lprod[42];
  end

  // phase and line divisions
  logic [PH_QW-1:0] ph;
  logic [LN_QW-1:0] lq;

  ppg_div #(.AW(42), .BW(CNT_W), .QW(PH_QW)) u_div_phase (
    .clk_i (clk_i),
    .a_i   ({idx0_q, 32'd0}),
    .b_i   (m0_q),
    .q_o   (ph)
  );

  ppg_div #(.AW(42), .BW(CNT_W), .QW(LN_QW)) u_div_line (
    .clk_i (clk_i),
    .a_i   (lmag_q),
    .b_i   (m0_q),
    .q_o   (lq)
  );

  // CORDIC rotation, one step per stage
  logic signed [32:0] cx_src [CORDIC_STEPS];
  logic signed [32:0] cy_src [CORDIC_STEPS];
  logic signed [31:0] cz_src [CORDIC_STEPS];
  logic [1:0]         cq_src [CORDIC_STEPS];
  logic signed [32:0] cx_q   [CORDIC_STEPS];
  logic signed [32:0] cy_q   [CORDIC_STEPS];
  logic signed [31:0] cz_q   [CORDIC_STEPS];
  logic [1:0]         cq_q   [CORDIC_STEPS];

  assign cx_src[0] = CORDIC_K;
  assign cy_src[0] = '0;
  assign cz_src[0] = $signed({2'b00, ph[29:0]});
  assign cq_src[0] = ph[31:30];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    if (i > 0) begin : g_link
      assign cx_src[i] = cx_q[i-1];
      assign cy_src[i] = cy_q[i-1];
      assign cz_src[i] = cz_q[i-1];
      assign cq_src[i] = cq_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      cq_q[i] <= cq_src[i];
      if (!cz_src[i][31]) begin
        cx_q[i] <= cx_src[i] - (cy_src[i] >>> i);
        cy_q[i] <= cy_src[i] + (cx_src[i] >>> i);
        cz_q[i] <= cz_src[i] - ATAN_TURN[i];
      end else begin
        cx_q[i] <= cx_src[i] + (cy_src[i] >>> i);
        cy_q[i] <= cy_src[i] - (cx_src[i] >>> i);
        cz_q[i] <= cz_src[i] + ATAN_TURN[i];
      end
    end
  end

  // quadrant fold
  logic signed [32:0] c_q, s_q;
  logic signed [32:0] fx, fy;

  assign fx = cx_q[CORDIC_STEPS-1];
  assign fy = cy_q[CORDIC_STEPS-1];

  always_ff @(posedge clk_i) begin
    case (cq_q[CORDIC_STEPS-1])
      QUAD_0: begin
        c_q <= fx;
        s_q <= fy;
      end
      QUAD_1: begin
        c_q <= -fy;
        s_q <= fx;
      end
      QUAD_2: begin
        c_q <= -fx;
        s_q <= -fy;
      end
      default: begin
        c_q <= fy;
        s_q <= -fx;
      end
    endcase
  end

  // products
  logic signed [64:0] pc_q, ps_q, pc_d, ps_d;
  logic signed [65:0] pss_q, pcs_q, pss_d, pcs_d;

  assign pc_d  = cfg_i.dim * c_q;
  assign ps_d  = cfg_i.dim * s_q;
  assign pss_d = s_q * s_q;
  assign pcs_d = c_q * s_q;

  always_ff @(posedge clk_i) begin
    pc_q  <= pc_d;
    ps_q  <= ps_d;
    pss_q <= pss_d;
    pcs_q <= pcs_d;
  end

  // circle result, lemniscate denominator and c*s
  logic signed [31:0] circ_x_q, circ_y_q;
  logic [31:0]        d_q;
  logic signed [32:0] csv_q;
  logic signed [64:0] pc2_q;

  always_ff @(posedge clk_i) begin
    circ_x_q <= sat32(72'(pc_q + 65'sd536870912) >>> 30);
    circ_y_q <= sat32(72'(ps_q + 65'sd536870912) >>> 30);
    d_q      <= 32'h4000_0000 + 32'((pss_q + 66'sd536870912) >>> 30);
    csv_q    <= 33'((pcs_q + 66'sd536870912) >>> 30);
    pc2_q    <= pc_q;
  end

  logic signed [64:0] py_q, pc3_q, py_d;
  logic [31:0]        d3_q;

  assign py_d = cfg_i.dim * csv_q;

  always_ff @(posedge clk_i) begin
    py_q  <= py_d;
    pc3_q <= pc2_q;
    d3_q  <= d_q;
  end

  // magnitudes plus half the divisor for round-half-away
  logic [62:0]        magx_q, magy_q;
  logic [31:0]        dd_q;
  logic               negx_q, negy_q;
  logic signed [64:0] absx, absy;

  assign absx = pc3_q[64] ? -pc3_q : pc3_q;
  assign absy = py_q[64] ? -py_q : py_q;

  always_ff @(posedge clk_i) begin
    magx_q <= absx[62:0] + 63'(d3_q >> 1);
    magy_q <= absy[62:0] + 63'(d3_q >> 1);
    negx_q <= pc3_q[64];
    negy_q <= py_q[64];
    dd_q   <= d3_q;
  end

  logic [LM_QW-1:0] lxq, lyq;

  ppg_div #(.AW(63), .BW(32), .QW(LM_QW)) u_div_lx (
    .clk_i (clk_i),
    .a_i   (magx_q),
    .b_i   (dd_q),
    .q_o   (lxq)
  );

  ppg_div #(.AW(63), .BW(32), .QW(LM_QW)) u_div_ly (
    .clk_i (clk_i),
    .a_i   (magy_q),
    .b_i   (dd_q),
    .q_o   (lyq)
  );

  // align side results with the lemniscate quotients
  logic [LN_QW-1:0] lq_dl   [DL_LNQ];
  logic             lneg_dl [T_END];
  logic [63:0]      circ_dl [DL_CIRC];
  logic [1:0]       lsg_dl  [LM_QW];

  always_ff @(posedge clk_i) begin
    lq_dl[0]   <= lq;
    lneg_dl[0] <= lneg_q;
    circ_dl[0] <= {circ_x_q, circ_y_q};
    lsg_dl[0]  <= {negx_q, negy_q};
    for (int k = 1; k < DL_LNQ; k++) begin
      lq_dl[k] <= lq_dl[k-1];
    end
    for (int k = 1; k < T_END; k++) begin
      lneg_dl[k] <= lneg_dl[k-1];
    end
    for (int k = 1; k < DL_CIRC; k++) begin
      circ_dl[k] <= circ_dl[k-1];
    end
    for (int k = 1; k < LM_QW; k++) begin
      lsg_dl[k] <= lsg_dl[k-1];
    end
  end

  // final select and saturation
  logic signed [71:0] lsum, lxv, lyv;
  logic signed [31:0] line_v;
  logic [LN_QW-1:0]   lq_e;
  logic [1:0]         lsg_e;
  logic [63:0]        circ_e;
  logic signed [31:0] x_d, y_d, z_d;
  logic               done_q;
  logic signed [31:0] x_q, y_q, z_q;

  assign lq_e   = lq_dl[DL_LNQ-1];
  assign lsg_e  = lsg_dl[LM_QW-1];
  assign circ_e = circ_dl[DL_CIRC-1];

  always_comb begin
    lsum   = 72'sd65536 + (lneg_dl[T_END-1] ? -72'(lq_e) : 72'(lq_e));
    lxv    = lsg_e[1] ? -72'(lxq) : 72'(lxq);
    lyv    = lsg_e[0] ? -72'(lyq) : 72'(lyq);
    line_v = sat32(lsum);
    case (cfg_i.style)
      STYLE_LINE: begin
        x_d = line_v;
        y_d = line_v;
        z_d = line_v;
      end
      STYLE_CIRCLE: begin
        x_d = circ_e[63:32];
        y_d = circ_e[31:0];
        z_d = ONE_Q16;
      end
      STYLE_LEMNI: begin
        x_d = sat32(lxv);
        y_d = sat32(lyv);
        z_d = ONE_Q16;
      end
      default: begin
        x_d = '0;
        y_d = '0;
        z_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[T_END];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o  = done_q;
  assign x_pos_o = x_q;
  assign y_pos_o = y_q;
  assign z_pos_o = z_q;

endmodule

// ----- hdl/parametric_path_point_generator.sv -----
// Top level of the parametric path point generator: register port, front end, queue, back end.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  config    | psel penable pwrite paddr pwdata prdata   | in / out
//  index     | start busy point_index_i                  | in / out
//  waypoint  | done_o x_pos_o y_pos_o z_pos_o            | out
//
// One index is taken per cycle while busy is low.
// The path runs through the 33-stage phase divider, the 24-stage CORDIC and the
// 33-stage rounding dividers, all fully pipelined.
// Reset clears the control state and loads the register defaults.
// done_o lasts one cycle and cannot be held off; busy stays low in practice.
module parametric_path_point_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [9:0]          point_index_i,
  output logic                done_o,
  output logic signed [31:0]  x_pos_o,
  output logic signed [31:0]  y_pos_o,
  output logic signed [31:0]  z_pos_o
);
  import ppg_pkg::*;

  cfg_t  cfg_q;
  logic  wr_en;
  logic  push, full, fvalid;
  item_t fitem, qitem;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.style <= STYLE_LINE;
      cfg_q.dim   <= ONE_Q16;
      cfg_q.count <= CNT_W'(50);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_STYLE: cfg_q.style <= pwdata[1:0];
        REG_DIM:   cfg_q.dim   <= pwdata;
        REG_COUNT: cfg_q.count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STYLE: prdata = {30'd0, cfg_q.style};
      REG_DIM:   prdata = cfg_q.dim;
      REG_COUNT: prdata = {21'd0, cfg_q.count};
      default:   prdata = '0;
    endcase
  end

  assign busy = full;

  ppg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .full_i        (full),
    .point_index_i (point_index_i),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .item_o        (fitem)
  );

  ppg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fitem),
    .pop_i   (fvalid),
    .valid_o (fvalid),
    .full_o  (full),
    .item_o  (qitem)
  );

  ppg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fvalid),
    .item_i  (qitem),
    .cfg_i   (cfg_q),
    .done_o  (done_o),
    .x_pos_o (x_pos_o),
    .y_pos_o (y_pos_o),
    .z_pos_o (z_pos_o)
  );

`ifndef SYNTHESIS
  a_curve_z_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (cfg_q.style == STYLE_CIRCLE || cfg_q.style == STYLE_LEMNI)
    |-> z_pos_o == ONE_Q16)
    else $error("curve waypoint z is not 1.0");
  a_line_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && cfg_q.style == STYLE_LINE |-> x_pos_o == y_pos_o && y_pos_o == z_pos_o)
    else $error("line waypoint off the diagonal");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");
`endif

endmodule

// ----- bench/parametric_path_point_generator_test.sv -----
// Testbench for the parametric path point generator: queued index driver, waypoint predictor.
`timescale 1ns / 100ps
module parametric_path_point_generator_test;
  import ppg_pkg::*;

  localparam int LATENCY = 99;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } waypoint_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [9:0] point_index_i = '0;
  logic done_o;
  logic signed [31:0] x_pos_o, y_pos_o, z_pos_o;

  parametric_path_point_generator u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [1:0] cur_style = STYLE_LINE;
  logic signed [31:0] cur_dim = 32'sd65536;
  logic [CNT_W-1:0] cur_count = 11'd50;

  logic [9:0] pending_idx[$];
  waypoint_t waypoints_due[$];
  int idle_pct = 0;
  int errors = 0;
  bit hold_sender = 1'b0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic waypoint_t compute_waypoint(logic [9:0] index);
    waypoint_t w;
    longint cnt, m, idx, dimv, px, py, pz, dx, dy, c, s, d, cs, v;
    logic [31:0] phase;
    logic [63:0] num;
    cnt = cur_count;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    m = cnt - 1;
    idx = index;
    if (idx > m) idx = m;
    dimv = cur_dim;
    w.x = 0; w.y = 0; w.z = 0;
    if (cur_style == STYLE_LINE) begin
      v = clip32(65536 + round_div(idx * dimv, m));
      w.x = v[31:0]; w.y = v[31:0]; w.z = v[31:0];
    end else if (cur_style == STYLE_CIRCLE || cur_style == STYLE_LEMNI) begin
      num = idx;
      num = (num << 32) / m;
      phase = num[31:0];
      px = 64'h26DD3B6A; py = 0; pz = phase[29:0];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = shr_floor(py, i);
        dy = shr_floor(px, i);
        if (pz >= 0) begin
          px -= dx; py += dy; pz -= longint'(ATAN_TURN[i]);
        end else begin
          px += dx; py -= dy; pz += longint'(ATAN_TURN[i]);
        end
      end
      case (phase[31:30])
        2'd0: begin c = px; s = py; end
        2'd1: begin c = -py; s = px; end
        2'd2: begin c = -px; s = -py; end
        default: begin c = py; s = -px; end
      endcase
      if (cur_style == STYLE_CIRCLE) begin
        v = clip32(shr_floor(dimv * c + (64'sd1 <<< 29), 30)); w.x = v[31:0];
        v = clip32(shr_floor(dimv * s + (64'sd1 <<< 29), 30)); w.y = v[31:0];
      end else begin
        d = (64'sd1 <<< 30) + shr_floor(s * s + (64'sd1 <<< 29), 30);
        cs = shr_floor(c * s + (64'sd1 <<< 29), 30);
        v = clip32(round_div(dimv * c, d)); w.x = v[31:0];
        v = clip32(round_div(dimv * cs, d)); w.y = v[31:0];
      end
      w.z = ONE_Q16;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  task automatic enqueue_index(logic [9:0] v);
    pending_idx.insert(pending_idx.size(), v);
  endtask

  // driver: one transaction per accepted start
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        waypoints_due.insert(waypoints_due.size(), compute_waypoint(point_index_i));
      end
      if (!(start && busy)) begin
        if (!hold_sender && pending_idx.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          point_index_i <= pending_idx.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (waypoints_due.size() == 0) begin
        report_mismatch("unexpected waypoint x_pos", x_pos_o, 32'h0);
      end else begin
        waypoint_t w;
        w = waypoints_due.pop_front();
        if (x_pos_o !== w.x) report_mismatch("x_pos", x_pos_o, w.x);
        if (y_pos_o !== w.y) report_mismatch("y_pos", y_pos_o, w.y);
        if (z_pos_o !== w.z) report_mismatch("z_pos", z_pos_o, w.z);
      end
    end
  end

  task automatic wait_drained();
    while (pending_idx.size() > 0 || start || waypoints_due.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] reg_sel, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {reg_sel, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_sel)
      REG_STYLE: cur_style = value[1:0];
      REG_DIM: cur_dim = value;
      REG_COUNT: cur_count = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_random(int n, int cnt);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) enqueue_index(10'($urandom));
      else enqueue_index(10'($urandom_range(cnt)));
    end
  endtask

  task automatic random_dim(output logic [31:0] v);
    case ($urandom_range(4))
      0: v = 32'h7FFFFFFF;
      1: v = 32'h80000000;
      2: v = $urandom;
      default: v = $urandom_range(32'h00100000) - 32'h00080000;
    endcase
  endtask

  initial begin
    logic [31:0] dv;
    int cnt;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset settings, then extremes of every style
    enqueue_index(10'd0); enqueue_index(10'd49);
    enqueue_index(10'd1023); enqueue_index(10'd25);
    wait_drained();
    for (int st = 0; st < 4; st++) begin
      write_reg(REG_STYLE, st);
      write_reg(REG_DIM, st[0] ? 32'h7FFFFFFF : 32'h80000000);
      write_reg(REG_COUNT, st == 3 ? 32'd0 : (st == 2 ? 32'd2047 : 32'd4));
      enqueue_index(10'd0); enqueue_index(10'd1);
      enqueue_index(10'd2); enqueue_index(10'd3);
      enqueue_index(10'd1023);
      wait_drained();
    end
    // random phases with varying idle rates
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 81;
        2: idle_pct = 81;
        default: idle_pct = 31;
      endcase
      write_reg(REG_STYLE, $urandom_range(9) == 0 ? 3 : $urandom_range(2));
      random_dim(dv);
      write_reg(REG_DIM, dv);
      cnt = ($urandom_range(5) == 0) ? $urandom_range(2047) : $urandom_range(64, 2);
      write_reg(REG_COUNT, cnt);
      queue_random(48, cnt < 1024 ? cnt : 1023);
      if (ph == 6) begin
        while (pending_idx.size() > 24) @(posedge clk_i);
        hold_sender = 1'b1;
        while (start || waypoints_due.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ppg_pkg.sv
hdl/ppg_front.sv
hdl/ppg_fifo.sv
hdl/ppg_div.sv
hdl/ppg_back.sv
hdl/parametric_path_point_generator.sv
bench/parametric_path_point_generator_test.sv
